>>> sv/hics_pkg.sv
// shared types and constants of the histogram inverse-cdf sampler
package hics_pkg;

   localparam int FRAC_W   = 24;
   localparam int WEIGHT_W = 16;
   localparam int EDGE_W   = 32;
   localparam int BINS_W   = 6;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 64;

   localparam logic [FRAC_W-1:0] FRAC_MASK = {FRAC_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_WEIGHT = 2'd0,
      KIND_X_EDGE = 2'd1,
      KIND_Y_EDGE = 2'd2,
      KIND_SAMPLE = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      REG_BINS_X = 1'b0,
      REG_BINS_Y = 1'b1
   } reg_index_type;

endpackage

>>> sv/histogram_inverse_cdf_sampler_core.sv
// histogram inverse-cdf sampler: loads weights and edges, draws 1d or 2d samples
//
// channel  dir  fields (lowest bit up)
// req      in   tdata: index, weight, edge_value, r_first, r_second; tuser: kind
// rsp      out  tdata: x_pos, y_pos; tuser: empty_error
// csr      in   we, index, wdata: bins_x, bins_y
//
// a sample runs the binary search over the cumulative memory, then the serial
// divider
// the first sample after a weight or csr write first rebuilds the cumulative
// table over the bins in use
// after reset a clearing pass zeroes all MAX_BINS_X*MAX_BINS_Y weights
// a result waiting in the output register stalls only the next sample's end
module histogram_inverse_cdf_sampler_core
   import hics_pkg::*;
#(
   parameter int MAX_BINS_X = 32,
   parameter int MAX_BINS_Y = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // index, weight, edge_value, r_first, r_second
   input  logic [1:0]            req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // x_pos, y_pos
   output logic [0:0]            rsp_tuser,  // empty_error
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [BINS_W-1:0]     csr_wdata
);

   localparam int FLAT  = MAX_BINS_X * MAX_BINS_Y;
   localparam int FAW   = (FLAT > 1) ? $clog2(FLAT) : 1;
   localparam int BXW   = $clog2(MAX_BINS_X + 1);
   localparam int BYW   = $clog2(MAX_BINS_Y + 1);
   localparam int CUM_W = WEIGHT_W + FAW;
   localparam int TW    = FRAC_W + CUM_W;
   localparam int PW    = FRAC_W + EDGE_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_BUILD_RD, S_BUILD_WR, S_MUL, S_SRCH, S_CMP, S_FETCH,
      S_DIV, S_E0, S_E1, S_E2, S_PX, S_PY, S_FIN, S_OUT
   } state_type;

   state_type state_ff;

   logic [9:0]          in_index;
   logic [WEIGHT_W-1:0] in_weight;
   logic [EDGE_W-1:0]   in_edge;
   logic [FRAC_W-1:0]   in_r1;
   logic [FRAC_W-1:0]   in_r2;
   kind_type            in_kind;
   logic                accept;

   assign in_index  = req_tdata[9:0];
   assign in_weight = req_tdata[25:10];
   assign in_edge   = req_tdata[57:26];
   assign in_r1     = req_tdata[81:58];
   assign in_r2     = req_tdata[106:83];
   assign in_kind   = kind_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic [BXW-1:0]      bx_ff;
   logic [BYW-1:0]      by_ff;
   logic [FAW:0]        n_ff;
   logic                stale_ff;
   logic [CUM_W-1:0]    total_ff;
   logic [CUM_W-1:0]    sum_ff;
   logic [FAW-1:0]      cnt_ff;
   logic [FAW-1:0]      lo_ff;
   logic [FAW-1:0]      hi_ff;
   logic [FAW-1:0]      mid_ff;
   logic [TW-1:0]       target_ff;
   logic [FRAC_W-1:0]   r1_ff;
   logic [FRAC_W-1:0]   r2_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic                fdiv_used_ff;
   logic [BXW-1:0]      i_ff;
   logic [BYW-1:0]      j_ff;
   logic [EDGE_W-1:0]   xlo_ff;
   logic [EDGE_W-1:0]   xhi_ff;
   logic [EDGE_W-1:0]   ylo_ff;
   logic [EDGE_W-1:0]   yhi_ff;
   logic [PW-1:0]       px_ff;
   logic [PW-1:0]       py_ff;
   logic                xneg_ff;
   logic                yneg_ff;
   logic [EDGE_W-1:0]   xres_ff;
   logic [EDGE_W-1:0]   yres_ff;
   logic                err_ff;
   logic                rsp_valid_ff;
   logic [EDGE_W-1:0]   rsp_x_ff;
   logic [EDGE_W-1:0]   rsp_y_ff;
   logic                rsp_err_ff;

   function automatic logic [BXW-1:0] clamp_x(input logic [BINS_W-1:0] v);
      logic [BXW-1:0] r;
      if (v == '0) r = BXW'(1);
      else if (int'(v) > MAX_BINS_X) r = BXW'(MAX_BINS_X);
      else r = BXW'(v);
      return r;
   endfunction

   function automatic logic [BYW-1:0] clamp_y(input logic [BINS_W-1:0] v);
      logic [BYW-1:0] r;
      if (v == '0) r = BYW'(1);
      else if (int'(v) > MAX_BINS_Y) r = BYW'(MAX_BINS_Y);
      else r = BYW'(v);
      return r;
   endfunction

   // weight memory
   logic                w_we;
   logic [FAW-1:0]      w_waddr;
   logic [WEIGHT_W-1:0] w_wdata;
   logic [FAW-1:0]      w_raddr;
   logic [WEIGHT_W-1:0] w_rdata;

   assign w_we    = (state_ff == S_CLEAR) ||
                    (accept && in_kind == KIND_WEIGHT && int'(in_index) < FLAT);
   assign w_waddr = (state_ff == S_CLEAR) ? cnt_ff : FAW'(in_index);
   assign w_wdata = (state_ff == S_CLEAR) ? '0 : in_weight;
   assign w_raddr = (state_ff == S_BUILD_RD) ? cnt_ff : lo_ff;

   hics_ram #(.WIDTH(WEIGHT_W), .DEPTH(FLAT)) u_weight_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   // cumulative memory
   logic [FAW:0]        mid_sum;
   logic [FAW-1:0]      mid_calc;
   logic [FAW-1:0]      c_raddr;
   logic [CUM_W-1:0]    c_rdata;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} + (FAW+1)'(1);
   assign mid_calc = mid_sum[FAW:1];
   assign c_raddr  = (state_ff == S_SRCH && lo_ff < hi_ff) ? mid_calc : lo_ff;

   hics_ram #(.WIDTH(CUM_W), .DEPTH(FLAT)) u_cum_ram (
      .clock (clock),
      .we    (state_ff == S_BUILD_WR),
      .waddr (cnt_ff),
      .wdata (sum_ff),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   // edge memories
   logic [EDGE_W-1:0] xe_rdata;
   logic [EDGE_W-1:0] ye_rdata;
   logic [BXW-1:0]    xe_raddr;
   logic [BYW-1:0]    ye_raddr;

   assign xe_raddr = (state_ff == S_E1) ? i_ff + BXW'(1) : i_ff;
   assign ye_raddr = (state_ff == S_E1) ? j_ff + BYW'(1) : j_ff;

   hics_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_BINS_X + 1)) u_x_edge_ram (
      .clock (clock),
      .we    (accept && in_kind == KIND_X_EDGE && int'(in_index) <= MAX_BINS_X),
      .waddr (BXW'(in_index)),
      .wdata (in_edge),
      .raddr (xe_raddr),
      .rdata (xe_rdata)
   );

   hics_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_BINS_Y + 1)) u_y_edge_ram (
      .clock (clock),
      .we    (accept && in_kind == KIND_Y_EDGE && int'(in_index) <= MAX_BINS_Y),
      .waddr (BYW'(in_index)),
      .wdata (in_edge),
      .raddr (ye_raddr),
      .rdata (ye_rdata)
   );

   // dividers: flat bin split and leftover fraction
   logic [TW-1:0]     resid;
   logic [CUM_W-1:0]  resid_hi;
   logic              fdiv_go;
   logic              kdiv_done;
   logic [FAW-1:0]    kdiv_q;
   logic [BYW-1:0]    kdiv_r;
   logic              fdiv_done;
   logic [FRAC_W-1:0] fdiv_q;
   logic [WEIGHT_W-1:0] fdiv_r;

   assign resid    = target_ff - {c_rdata, {FRAC_W{1'b0}}};
   assign resid_hi = resid[TW-1:FRAC_W];
   assign fdiv_go  = (w_rdata != '0) && (resid_hi < CUM_W'(w_rdata));

   hics_div #(.QW(FAW), .VW(BYW)) u_bin_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_FETCH),
      .rem_init  ('0),
      .dividend  (lo_ff),
      .divisor   (by_ff),
      .done      (kdiv_done),
      .quotient  (kdiv_q),
      .remainder (kdiv_r)
   );

   hics_div #(.QW(FRAC_W), .VW(WEIGHT_W)) u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_FETCH && fdiv_go),
      .rem_init  (WEIGHT_W'(resid_hi)),
      .dividend  (resid[FRAC_W-1:0]),
      .divisor   (w_rdata),
      .done      (fdiv_done),
      .quotient  (fdiv_q),
      .remainder (fdiv_r)
   );

   // interpolation
   logic signed [EDGE_W:0] dx;
   logic signed [EDGE_W:0] dy;
   logic [EDGE_W:0]        dx_mag;
   logic [EDGE_W:0]        dy_mag;
   logic [PW:0]            px_up;
   logic [PW:0]            py_up;
   logic signed [EDGE_W+1:0] xoff;
   logic signed [EDGE_W+1:0] yoff;
   logic signed [EDGE_W+1:0] xsum;
   logic signed [EDGE_W+1:0] ysum;

   assign dx     = $signed({xhi_ff[EDGE_W-1], xhi_ff}) - $signed({xlo_ff[EDGE_W-1], xlo_ff});
   assign dy     = $signed({yhi_ff[EDGE_W-1], yhi_ff}) - $signed({ylo_ff[EDGE_W-1], ylo_ff});
   assign dx_mag = dx[EDGE_W] ? (EDGE_W+1)'(-dx) : (EDGE_W+1)'(dx);
   assign dy_mag = dy[EDGE_W] ? (EDGE_W+1)'(-dy) : (EDGE_W+1)'(dy);
   assign px_up  = {1'b0, px_ff} + (PW+1)'(FRAC_MASK);
   assign py_up  = {1'b0, py_ff} + (PW+1)'(FRAC_MASK);
   assign xoff   = xneg_ff ? -$signed({1'b0, px_up[PW:FRAC_W]})
                           : $signed({2'b00, px_ff[PW-1:FRAC_W]});
   assign yoff   = yneg_ff ? -$signed({1'b0, py_up[PW:FRAC_W]})
                           : $signed({2'b00, py_ff[PW-1:FRAC_W]});
   assign xsum   = $signed({{2{xlo_ff[EDGE_W-1]}}, xlo_ff}) + xoff;
   assign ysum   = $signed({{2{ylo_ff[EDGE_W-1]}}, ylo_ff}) + yoff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         bx_ff        <= BXW'(1);
         by_ff        <= BYW'(1);
         n_ff         <= (FAW+1)'(1);
         stale_ff     <= 1'b1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff <= (FAW+1)'(bx_ff * by_ff);
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_BINS_X: bx_ff <= clamp_x(csr_wdata);
               REG_BINS_Y: by_ff <= clamp_y(csr_wdata);
               default: ;
            endcase
            stale_ff <= 1'b1;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + FAW'(1);
               if (cnt_ff == FAW'(FLAT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  case (in_kind)
                     KIND_WEIGHT: begin
                        if (int'(in_index) < FLAT) stale_ff <= 1'b1;
                     end
                     KIND_SAMPLE: begin
                        r1_ff  <= in_r1;
                        r2_ff  <= in_r2;
                        cnt_ff <= '0;
                        sum_ff <= '0;
                        state_ff <= stale_ff ? S_BUILD_RD : S_MUL;
                     end
                     default: ;
                  endcase
               end
            end
            S_BUILD_RD: state_ff <= S_BUILD_WR;
            S_BUILD_WR: begin
               sum_ff <= sum_ff + CUM_W'(w_rdata);
               if (cnt_ff == FAW'(n_ff - (FAW+1)'(1))) begin
                  total_ff <= sum_ff + CUM_W'(w_rdata);
                  stale_ff <= 1'b0;
                  state_ff <= S_MUL;
               end else begin
                  cnt_ff   <= cnt_ff + FAW'(1);
                  state_ff <= S_BUILD_RD;
               end
            end
            S_MUL: begin
               target_ff <= TW'(r1_ff * total_ff);
               lo_ff     <= '0;
               hi_ff     <= FAW'(n_ff - (FAW+1)'(1));
               if (total_ff == '0) begin
                  xres_ff  <= '0;
                  yres_ff  <= '0;
                  err_ff   <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  err_ff   <= 1'b0;
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_calc;
                  state_ff <= S_CMP;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_CMP: begin
               if ({c_rdata, {FRAC_W{1'b0}}} <= target_ff) lo_ff <= mid_ff;
               else hi_ff <= mid_ff - FAW'(1);
               state_ff <= S_SRCH;
            end
            S_FETCH: begin
               fdiv_used_ff <= fdiv_go;
               frac_ff      <= (w_rdata == '0) ? '0 : FRAC_MASK;
               state_ff     <= S_DIV;
            end
            S_DIV: begin
               if (kdiv_done && (!fdiv_used_ff || fdiv_done)) begin
                  i_ff <= BXW'(kdiv_q);
                  j_ff <= kdiv_r;
                  if (fdiv_used_ff) frac_ff <= fdiv_q;
                  state_ff <= S_E0;
               end
            end
            S_E0: state_ff <= S_E1;
            S_E1: begin
               xlo_ff   <= xe_rdata;
               ylo_ff   <= ye_rdata;
               state_ff <= S_E2;
            end
            S_E2: begin
               xhi_ff   <= xe_rdata;
               yhi_ff   <= ye_rdata;
               state_ff <= S_PX;
            end
            S_PX: begin
               px_ff    <= PW'(frac_ff * dx_mag[EDGE_W-1:0]);
               xneg_ff  <= dx[EDGE_W];
               state_ff <= S_PY;
            end
            S_PY: begin
               py_ff    <= PW'(r2_ff * dy_mag[EDGE_W-1:0]);
               yneg_ff  <= dy[EDGE_W];
               state_ff <= S_FIN;
            end
            S_FIN: begin
               xres_ff  <= xsum[EDGE_W-1:0];
               yres_ff  <= ysum[EDGE_W-1:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= xres_ff;
                  rsp_y_ff     <= yres_ff;
                  rsp_err_ff   <= err_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_err_ff;

   logic unused_rem;
   assign unused_rem = ^fdiv_r;

endmodule

>>> sv/hics_ram.sv
// generic single-write, single-read memory with registered read data
module hics_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/hics_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module hics_div #(
   parameter int QW = 24,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [VW-1:0] rem_init,
   input  logic [QW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [VW-1:0] rem_ff;
   logic [QW-1:0] q_ff;
   logic [VW-1:0] div_ff;

   logic [VW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, q_ff[QW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         q_ff   <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? VW'(trial - {1'b0, div_ff}) : VW'(trial);
         q_ff   <= (q_ff << 1) | QW'(fits);
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule
